[hdl/circle_collision_resolve_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the circle collision resolver
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_COLLISION_RESOLVE_TOP_MACROS_SVH
`define CIRCLE_COLLISION_RESOLVE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CCR_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ccr: same-cycle check failed");
`define CCR_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ccr: next-cycle check failed");
`else
`define CCR_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define CCR_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

[hdl/ccr_pkg.sv]
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared constants and pipeline control type of the circle collision resolver.
// ----------------------------------------------------------------------------
package ccr_pkg;

   // Extra fraction bits carried by the distance.
   localparam int GUARD = 8;

   typedef struct packed {
      logic enable;
      logic valid;
   } pipe_ctl_type;

endpackage

[hdl/ccr_sqrt.sv]
// ----------------------------------------------------------------------------
// ccr_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ccr_sqrt #(
   parameter int RADICAND_WIDTH = 48,
   parameter int SIDE_WIDTH     = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccr_pkg::pipe_ctl_type         ctl,
   input  logic [RADICAND_WIDTH-1:0]     radicand,
   input  logic [SIDE_WIDTH-1:0]         side_in,
   output logic                          out_valid,
   output logic [RADICAND_WIDTH/2-1:0]   root,
   output logic [SIDE_WIDTH-1:0]         side_out
);
   import ccr_pkg::*;

   localparam int RW = RADICAND_WIDTH / 2;

   typedef logic [RADICAND_WIDTH:0]   trial_type;
   typedef logic [RADICAND_WIDTH-1:0] rem_type;
   typedef logic [RW-1:0]             root_type;

   logic                  valid_ff [RW];
   root_type              root_ff  [RW];
   rem_type               rem_ff   [RW];
   logic [SIDE_WIDTH-1:0] side_ff  [RW];
   root_type              root_in  [RW];
   rem_type               rem_in   [RW];

   for (genvar j = 0; j < RW; j++) begin : g_step
      localparam int I = RW - 1 - j;
      root_type  root_prev;
      rem_type   rem_prev;
      trial_type trial;
      logic      take;

      if (j == 0) begin : g_head
         assign root_prev = '0;
         assign rem_prev  = radicand;
      end else begin : g_body
         assign root_prev = root_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
      end

      assign trial      = (trial_type'(root_prev) << (I + 1)) + (trial_type'(1) << (2 * I));
      assign take       = trial_type'(rem_prev) >= trial;
      assign root_in[j] = take ? (root_prev | (root_type'(1) << I)) : root_prev;
      assign rem_in[j]  = take ? (rem_prev - trial[RADICAND_WIDTH-1:0]) : rem_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RW; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (ctl.enable) begin
         valid_ff[0] <= ctl.valid;
         for (int k = 1; k < RW; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         side_ff[0] <= side_in;
         for (int k = 0; k < RW; k++) begin
            root_ff[k] <= root_in[k];
            rem_ff[k]  <= rem_in[k];
         end
         for (int k = 1; k < RW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign side_out  = side_ff[RW-1];

endmodule

[hdl/ccr_div.sv]
// ----------------------------------------------------------------------------
// ccr_div
// Pipelined restoring divider, several lanes over one shared divisor,
// one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ccr_div #(
   parameter int LANES      = 4,
   parameter int NUM_WIDTH  = 45,
   parameter int DIV_WIDTH  = 25,
   parameter int QUO_WIDTH  = 20,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ccr_pkg::pipe_ctl_type               ctl,
   input  logic [LANES-1:0][NUM_WIDTH-1:0]     numerator,
   input  logic [DIV_WIDTH-1:0]                divisor,
   input  logic [SIDE_WIDTH-1:0]               side_in,
   output logic                                out_valid,
   output logic [LANES-1:0][QUO_WIDTH-1:0]     quotient,
   output logic [SIDE_WIDTH-1:0]               side_out
);
   import ccr_pkg::*;

   typedef logic [NUM_WIDTH-1:0]             num_type;
   typedef logic [QUO_WIDTH-1:0]             quo_type;
   typedef logic [DIV_WIDTH-1:0]             div_type;
   typedef logic [LANES-1:0][NUM_WIDTH-1:0]  lane_num_type;
   typedef logic [LANES-1:0][QUO_WIDTH-1:0]  lane_quo_type;

   logic                  valid_ff   [QUO_WIDTH];
   lane_num_type          rem_ff     [QUO_WIDTH];
   lane_quo_type          quo_ff     [QUO_WIDTH];
   div_type               divisor_ff [QUO_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff    [QUO_WIDTH];
   lane_num_type          rem_in     [QUO_WIDTH];
   lane_quo_type          quo_in     [QUO_WIDTH];

   for (genvar j = 0; j < QUO_WIDTH; j++) begin : g_step
      localparam int I = QUO_WIDTH - 1 - j;
      lane_num_type rem_prev;
      lane_quo_type quo_prev;
      div_type      divisor_prev;

      if (j == 0) begin : g_head
         assign rem_prev     = numerator;
         assign quo_prev     = '0;
         assign divisor_prev = divisor;
      end else begin : g_body
         assign rem_prev     = rem_ff[j-1];
         assign quo_prev     = quo_ff[j-1];
         assign divisor_prev = divisor_ff[j-1];
      end

      always_comb begin
         num_type shifted;
         shifted = num_type'(divisor_prev) << I;
         for (int l = 0; l < LANES; l++) begin
            if (rem_prev[l] >= shifted) begin
               rem_in[j][l] = rem_prev[l] - shifted;
               quo_in[j][l] = quo_prev[l] | (quo_type'(1) << I);
            end else begin
               rem_in[j][l] = rem_prev[l];
               quo_in[j][l] = quo_prev[l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_WIDTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (ctl.enable) begin
         valid_ff[0] <= ctl.valid;
         for (int k = 1; k < QUO_WIDTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         divisor_ff[0] <= divisor;
         side_ff[0]    <= side_in;
         for (int k = 0; k < QUO_WIDTH; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
         for (int k = 1; k < QUO_WIDTH; k++) begin
            divisor_ff[k] <= divisor_ff[k-1];
            side_ff[k]    <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[QUO_WIDTH-1];
   assign quotient  = quo_ff[QUO_WIDTH-1];
   assign side_out  = side_ff[QUO_WIDTH-1];

endmodule

[hdl/circle_collision_resolve_top.sv]
// ----------------------------------------------------------------------------
// circle_collision_resolve_top
// Static resolution of two touching or overlapping circles in fixed point.
// ----------------------------------------------------------------------------
// The block takes one item, a pair of circles, in every cycle while no result
// waits on rsp_ready, and returns one result item per pair. The pipeline runs
// through the square root, which resolves one root bit per stage, and then
// through the four-lane divider that follows it, which resolves one quotient
// bit per stage. The whole pipeline advances together and holds in place while
// a result waits on rsp_ready.
`include "circle_collision_resolve_top_macros.svh"

module circle_collision_resolve_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic [COORD_WIDTH-2:0]        req_first_radius,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic [COORD_WIDTH-2:0]        req_second_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_overlap,
   output logic                          rsp_coincident,
   output logic                          rsp_saturated,
   output logic signed [COORD_WIDTH-1:0] rsp_new_first_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_first_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_second_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_second_y
);
   import ccr_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int DXW   = CW + 1;
   localparam int SQW   = 2 * CW + 2 * GUARD;
   localparam int RW    = CW + GUARD;
   localparam int QW    = CW + 4;
   localparam int DW    = RW + 1;
   localparam int NW    = QW + DW;
   localparam int PW    = DXW + RW + 1;
   localparam int RPW   = 2 * CW + 1;
   localparam int LANES = 4;

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic [CW-2:0]         radius_type;
   typedef logic signed [DXW-1:0] delta_type;
   typedef logic [SQW-1:0]        rad_type;
   typedef logic [RW-1:0]         root_type;
   typedef logic signed [NW-1:0]  num_type;
   typedef logic [QW-1:0]         quo_type;
   typedef logic signed [QW:0]    wide_type;

   typedef struct packed {
      coord_type  x1;
      coord_type  y1;
      coord_type  x2;
      coord_type  y2;
      radius_type r1;
      radius_type r2;
      delta_type  dx;
      delta_type  dy;
      delta_type  sx;
      delta_type  sy;
      logic       ov;
      logic       co;
   } geom_type;

   typedef struct packed {
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
      logic      ov;
      logic      co;
   } pass_type;

   localparam coord_type C_LO = {1'b1, {(CW-1){1'b0}}};
   localparam coord_type C_HI = {1'b0, {(CW-1){1'b1}}};
   localparam wide_type  V_LO = {{(QW-CW+2){1'b1}}, {(CW-1){1'b0}}};
   localparam wide_type  V_HI = {{(QW-CW+2){1'b0}}, {(CW-1){1'b1}}};
   localparam wide_type  BIAS = {2'b01, {(QW-1){1'b0}}};

   logic pipe_en;

   // Input register.
   logic       a_valid_ff;
   coord_type  a_x1_ff, a_y1_ff, a_x2_ff, a_y2_ff;
   radius_type a_r1_ff, a_r2_ff;

   // Differences, sums and the radius sum.
   logic            b_valid_ff;
   geom_type        b_geom_ff, b_geom_in;
   logic [CW-1:0]   b_rs_ff;

   // Squares.
   logic              c_valid_ff;
   geom_type          c_geom_ff;
   logic [2*CW:0]     c_dx2_ff, c_dy2_ff, c_dx2_in, c_dy2_in;
   logic [2*CW-1:0]   c_rs2_ff;
   logic signed [2*DXW-1:0] dx_sq, dy_sq;

   // Squared distance and overlap test.
   logic          d_valid_ff;
   geom_type      d_geom_ff, d_geom_in;
   rad_type       d_rad_ff;
   logic [2*CW+1:0] d2;

   // Square root output.
   logic     e_valid;
   root_type e_root;
   geom_type e_geom;

   // Products.
   logic                   m_valid_ff;
   pass_type               m_pass_ff;
   root_type               m_root_ff;
   logic signed [PW-1:0]   m_sxs_ff, m_sys_ff, m_sxs_in, m_sys_in;
   logic signed [RPW-1:0]  m_r1dx_ff, m_r2dx_ff, m_r1dy_ff, m_r2dy_ff;
   logic signed [RPW-1:0]  m_r1dx_in, m_r2dx_in, m_r1dy_in, m_r2dy_in;

   // Biased numerators and the divisor.
   logic                        n_valid_ff;
   pass_type                    n_pass_ff;
   logic [LANES-1:0][NW-1:0]    n_num_ff, n_num_in;
   logic [DW-1:0]               n_div_ff;
   num_type                     base_x, base_y;

   // Divider output.
   logic                     q_valid;
   logic [LANES-1:0][QW-1:0] q_quo;
   pass_type                 q_pass;

   // Output register.
   logic      out_valid_ff;
   logic      out_overlap_ff, out_coincident_ff, out_saturated_ff;
   coord_type out_x1_ff, out_y1_ff, out_x2_ff, out_y2_ff;
   logic      fin_sat;
   coord_type fin_coord [LANES];
   coord_type orig_coord [LANES];
   logic      fin_use;

   assign pipe_en   = !out_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         n_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         a_valid_ff   <= req_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         m_valid_ff   <= e_valid;
         n_valid_ff   <= m_valid_ff;
         out_valid_ff <= q_valid;
      end
   end

   always_comb begin
      b_geom_in    = '0;
      b_geom_in.x1 = a_x1_ff;
      b_geom_in.y1 = a_y1_ff;
      b_geom_in.x2 = a_x2_ff;
      b_geom_in.y2 = a_y2_ff;
      b_geom_in.r1 = a_r1_ff;
      b_geom_in.r2 = a_r2_ff;
      b_geom_in.dx = delta_type'(a_x2_ff) - delta_type'(a_x1_ff);
      b_geom_in.dy = delta_type'(a_y2_ff) - delta_type'(a_y1_ff);
      b_geom_in.sx = delta_type'(a_x1_ff) + delta_type'(a_x2_ff);
      b_geom_in.sy = delta_type'(a_y1_ff) + delta_type'(a_y2_ff);
   end

   assign dx_sq    = b_geom_ff.dx * b_geom_ff.dx;
   assign dy_sq    = b_geom_ff.dy * b_geom_ff.dy;
   assign c_dx2_in = dx_sq[2*CW:0];
   assign c_dy2_in = dy_sq[2*CW:0];

   assign d2 = (2*CW+2)'(c_dx2_ff) + (2*CW+2)'(c_dy2_ff);

   always_comb begin
      d_geom_in    = c_geom_ff;
      d_geom_in.ov = d2 <= (2*CW+2)'(c_rs2_ff);
      d_geom_in.co = d2 == '0;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_x1_ff   <= req_first_x;
         a_y1_ff   <= req_first_y;
         a_r1_ff   <= req_first_radius;
         a_x2_ff   <= req_second_x;
         a_y2_ff   <= req_second_y;
         a_r2_ff   <= req_second_radius;
         b_geom_ff <= b_geom_in;
         b_rs_ff   <= CW'(a_r1_ff) + CW'(a_r2_ff);
         c_geom_ff <= b_geom_ff;
         c_dx2_ff  <= c_dx2_in;
         c_dy2_ff  <= c_dy2_in;
         c_rs2_ff  <= b_rs_ff * b_rs_ff;
         d_geom_ff <= d_geom_in;
         d_rad_ff  <= rad_type'(d2[2*CW-1:0]) << (2 * GUARD);
      end
   end

   ccr_sqrt #(
      .RADICAND_WIDTH (SQW),
      .SIDE_WIDTH     ($bits(geom_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{enable: pipe_en, valid: d_valid_ff}),
      .radicand  (d_rad_ff),
      .side_in   (d_geom_ff),
      .out_valid (e_valid),
      .root      (e_root),
      .side_out  (e_geom)
   );

   assign m_sxs_in  = e_geom.sx * $signed({1'b0, e_root});
   assign m_sys_in  = e_geom.sy * $signed({1'b0, e_root});
   assign m_r1dx_in = $signed({1'b0, e_geom.r1}) * e_geom.dx;
   assign m_r2dx_in = $signed({1'b0, e_geom.r2}) * e_geom.dx;
   assign m_r1dy_in = $signed({1'b0, e_geom.r1}) * e_geom.dy;
   assign m_r2dy_in = $signed({1'b0, e_geom.r2}) * e_geom.dy;

   assign base_x = num_type'(m_sxs_ff) + num_type'(m_root_ff) + (num_type'(m_root_ff) << QW);
   assign base_y = num_type'(m_sys_ff) + num_type'(m_root_ff) + (num_type'(m_root_ff) << QW);

   // The first circle moves away from the second, so its offset is negated.
   assign n_num_in[0] = base_x - (num_type'(m_r1dx_ff) <<< (GUARD + 1));
   assign n_num_in[1] = base_y - (num_type'(m_r1dy_ff) <<< (GUARD + 1));
   assign n_num_in[2] = base_x + (num_type'(m_r2dx_ff) <<< (GUARD + 1));
   assign n_num_in[3] = base_y + (num_type'(m_r2dy_ff) <<< (GUARD + 1));

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_pass_ff <= '{x1: e_geom.x1, y1: e_geom.y1, x2: e_geom.x2, y2: e_geom.y2,
                        ov: e_geom.ov, co: e_geom.co};
         m_root_ff <= e_root;
         m_sxs_ff  <= m_sxs_in;
         m_sys_ff  <= m_sys_in;
         m_r1dx_ff <= m_r1dx_in;
         m_r2dx_ff <= m_r2dx_in;
         m_r1dy_ff <= m_r1dy_in;
         m_r2dy_ff <= m_r2dy_in;
         n_pass_ff <= m_pass_ff;
         n_num_ff  <= n_num_in;
         n_div_ff  <= {m_root_ff, 1'b0};
      end
   end

   ccr_div #(
      .LANES      (LANES),
      .NUM_WIDTH  (NW),
      .DIV_WIDTH  (DW),
      .QUO_WIDTH  (QW),
      .SIDE_WIDTH ($bits(pass_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{enable: pipe_en, valid: n_valid_ff}),
      .numerator (n_num_ff),
      .divisor   (n_div_ff),
      .side_in   (n_pass_ff),
      .out_valid (q_valid),
      .quotient  (q_quo),
      .side_out  (q_pass)
   );

   assign orig_coord[0] = q_pass.x1;
   assign orig_coord[1] = q_pass.y1;
   assign orig_coord[2] = q_pass.x2;
   assign orig_coord[3] = q_pass.y2;
   assign fin_use       = q_pass.ov && !q_pass.co;

   always_comb begin
      wide_type v;
      fin_sat = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         v = $signed({1'b0, q_quo[l]}) - BIAS;
         if (!fin_use) begin
            fin_coord[l] = orig_coord[l];
         end else if (v < V_LO) begin
            fin_coord[l] = C_LO;
            fin_sat      = 1'b1;
         end else if (v > V_HI) begin
            fin_coord[l] = C_HI;
            fin_sat      = 1'b1;
         end else begin
            fin_coord[l] = v[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_overlap_ff    <= q_pass.ov;
         out_coincident_ff <= q_pass.ov && q_pass.co;
         out_saturated_ff  <= fin_sat;
         out_x1_ff         <= fin_coord[0];
         out_y1_ff         <= fin_coord[1];
         out_x2_ff         <= fin_coord[2];
         out_y2_ff         <= fin_coord[3];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_overlap      = out_overlap_ff;
   assign rsp_coincident   = out_coincident_ff;
   assign rsp_saturated    = out_saturated_ff;
   assign rsp_new_first_x  = out_x1_ff;
   assign rsp_new_first_y  = out_y1_ff;
   assign rsp_new_second_x = out_x2_ff;
   assign rsp_new_second_y = out_y2_ff;

   `CCR_ASSERT_IMPLY(a_coincident_overlap, clock, reset, rsp_valid && rsp_coincident, rsp_overlap)
   `CCR_ASSERT_IMPLY(a_sat_resolved, clock, reset, rsp_valid && rsp_saturated, rsp_overlap && !rsp_coincident)
   `CCR_ASSERT_IMPLY(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, rsp_new_first_x == C_LO || rsp_new_first_x == C_HI || rsp_new_first_y == C_LO || rsp_new_first_y == C_HI || rsp_new_second_x == C_LO || rsp_new_second_x == C_HI || rsp_new_second_y == C_LO || rsp_new_second_y == C_HI)
   `CCR_ASSERT_NEXT(a_stall_freezes, clock, reset, !pipe_en, $stable(d_valid_ff) && $stable(n_valid_ff))

endmodule

[dv/ccr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circle collision resolver result checker
// Watches both channels, predicts each result item from the accepted request
// item and compares every field against the oldest prediction in order.
// ----------------------------------------------------------------------------
module ccr_checker #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic [COORD_WIDTH-2:0]        req_first_radius,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic [COORD_WIDTH-2:0]        req_second_radius,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_overlap,
   input  logic                          rsp_coincident,
   input  logic                          rsp_saturated,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_first_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_first_y,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_second_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_second_y,
   output int                            fail_count,
   output int                            pending_count
);

   typedef struct packed {
      logic                          overlap;
      logic                          coincident;
      logic                          saturated;
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
   } placement_type;

   placement_type placement_queue[$];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic longint place_coord(longint sum, longint radius, longint delta,
                                          longint distance, ref logic sat);
      longint lo;
      longint hi;
      longint num;
      longint den;
      longint quo;
      lo = -(longint'(1) << (COORD_WIDTH - 1));
      hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
      num = sum * distance + radius * delta * (longint'(1) << (ccr_pkg::GUARD + 1))
            + distance;
      den = 2 * distance;
      quo = num / den;
      if ((num % den) != 0 && num < 0) quo = quo - 1;
      if (quo < lo) begin
         sat = 1'b1;
         return lo;
      end
      if (quo > hi) begin
         sat = 1'b1;
         return hi;
      end
      return quo;
   endfunction

   function automatic placement_type resolve_pair();
      placement_type res;
      longint x1, y1, x2, y2, r1, r2, dx, dy, distance;
      longint unsigned d2, rsum;
      logic sat;
      x1 = longint'(req_first_x);
      y1 = longint'(req_first_y);
      x2 = longint'(req_second_x);
      y2 = longint'(req_second_y);
      r1 = longint'(req_first_radius);
      r2 = longint'(req_second_radius);
      dx = x2 - x1;
      dy = y2 - y1;
      d2 = dx * dx + dy * dy;
      rsum = r1 + r2;
      sat = 1'b0;
      res.overlap = (d2 <= rsum * rsum);
      res.coincident = 1'b0;
      res.first_x = req_first_x;
      res.first_y = req_first_y;
      res.second_x = req_second_x;
      res.second_y = req_second_y;
      if (res.overlap) begin
         if (d2 == 0) begin
            res.coincident = 1'b1;
         end else begin
            distance = int_sqrt(d2 << (2 * ccr_pkg::GUARD));
            res.first_x = COORD_WIDTH'(place_coord(x1 + x2, r1, -dx, distance, sat));
            res.first_y = COORD_WIDTH'(place_coord(y1 + y2, r1, -dy, distance, sat));
            res.second_x = COORD_WIDTH'(place_coord(x1 + x2, r2, dx, distance, sat));
            res.second_y = COORD_WIDTH'(place_coord(y1 + y2, r2, dy, distance, sat));
         end
      end
      res.saturated = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      placement_type want;
      placement_type got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) placement_queue.push_back(resolve_pair());
         if (rsp_valid && rsp_ready) begin
            got = {rsp_overlap, rsp_coincident, rsp_saturated, rsp_new_first_x,
                   rsp_new_first_y, rsp_new_second_x, rsp_new_second_y};
            if (placement_queue.size() == 0) begin
               $display("%t unexpected result item: actual %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = placement_queue.pop_front();
               if (want !== got) begin
                  $display("%t mismatch: expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= placement_queue.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circle collision resolver testbench
// Sends directed and random circle pairs with random idling on both sides and
// a long result stall, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CW = 16;
   localparam int RANDOM_ITEMS = 1130;
   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [CW-1:0] req_first_x;
   logic signed [CW-1:0] req_first_y;
   logic [CW-2:0]        req_first_radius;
   logic signed [CW-1:0] req_second_x;
   logic signed [CW-1:0] req_second_y;
   logic [CW-2:0]        req_second_radius;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_overlap;
   logic                 rsp_coincident;
   logic                 rsp_saturated;
   logic signed [CW-1:0] rsp_new_first_x;
   logic signed [CW-1:0] rsp_new_first_y;
   logic signed [CW-1:0] rsp_new_second_x;
   logic signed [CW-1:0] rsp_new_second_y;
   int                   fail_count;
   int                   pending_count;
   int                   cycle_count = 0;
   logic                 idle_off;

   circle_collision_resolve_top #(.COORD_WIDTH(CW)) u_dut (.*);

   ccr_checker #(.COORD_WIDTH(CW)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[circle_collision_resolve_top] ERROR");
         $finish;
      end
   end

   // Result side: one long hold-off early on, then random stall bursts.
   initial begin
      int burst;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      repeat (40) @(posedge clock);
      repeat (300) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!idle_off && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_pair(input logic [CW-1:0] x1, input logic [CW-1:0] y1,
                            input logic [CW-2:0] r1, input logic [CW-1:0] x2,
                            input logic [CW-1:0] y2, input logic [CW-2:0] r2);
      int burst;
      if (!idle_off && $urandom_range(0, 7) == 0) begin
         burst = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (burst) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_x <= x1;
      req_first_y <= y1;
      req_first_radius <= r1;
      req_second_x <= x2;
      req_second_y <= y2;
      req_second_radius <= r2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly overlapping pairs: second center placed near the first.
   task automatic send_random_pair();
      logic [CW-1:0] x1, y1;
      logic [CW-2:0] r1, r2;
      int span, mode;
      mode = $urandom_range(0, 9);
      x1 = CW'($urandom);
      y1 = CW'($urandom);
      r1 = (CW-1)'($urandom);
      r2 = (CW-1)'($urandom);
      if (mode < 2) begin
         send_pair(x1, y1, r1, CW'($urandom), CW'($urandom), r2);
      end else begin
         if (mode < 6) begin
            r1 = (CW-1)'($urandom_range(0, 2047));
            r2 = (CW-1)'($urandom_range(0, 2047));
         end
         span = $urandom_range(0, 1) ? 64 : 4096;
         send_pair(x1, y1, r1, CW'(x1 + $urandom_range(0, 2 * span) - span),
                   CW'(y1 + $urandom_range(0, 2 * span) - span), r2);
      end
   endtask

   initial begin
      localparam logic [CW-1:0] CMAX = 16'h7fff;
      localparam logic [CW-1:0] CMIN = 16'h8000;
      localparam logic [CW-2:0] RMAX = 15'h7fff;
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_x = '0;
      req_first_y = '0;
      req_first_radius = '0;
      req_second_x = '0;
      req_second_y = '0;
      req_second_radius = '0;
      idle_off = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pair(16'd100, 16'd100, 15'd50, 16'd300, 16'd100, 15'd50);
      send_pair(16'd100, 16'd100, 15'd80, 16'd200, 16'd100, 15'd80);
      send_pair(16'd0, 16'd0, 15'd16, 16'd32, 16'd0, 15'd16);
      send_pair(16'd0, 16'd0, 15'd16, 16'd33, 16'd0, 15'd16);
      send_pair(16'd5, 16'd7, 15'd3, 16'd5, 16'd7, 15'd9);
      send_pair(16'd5, 16'd7, 15'd0, 16'd5, 16'd7, 15'd0);
      send_pair(CMIN, CMIN, RMAX, CMAX, CMAX, RMAX);
      send_pair(CMAX, CMAX, RMAX, CMIN, CMIN, RMAX);
      send_pair(CMAX, CMAX, RMAX, CMAX - 16'd1, CMAX, RMAX);
      send_pair(CMIN, CMIN, RMAX, CMIN + 16'd1, CMIN + 16'd1, RMAX);
      send_pair(CMAX, 16'd0, 15'd100, CMAX - 16'd10, 16'd0, 15'd100);
      send_pair(CMIN, 16'd0, 15'd100, CMIN + 16'd10, 16'd0, 15'd100);
      send_pair(16'd0, CMAX, 15'd100, 16'd0, CMAX - 16'd10, 15'd100);
      send_pair(16'd0, CMIN, 15'd100, 16'd0, CMIN + 16'd10, 15'd100);
      send_pair(16'hffff, 16'hffff, 15'd1, 16'd0, 16'd0, 15'd1);
      send_pair(16'd0, 16'd0, RMAX, 16'd0, 16'd1, 15'd0);
      send_pair(16'h5555, 16'haaaa, 15'h2aaa, 16'h5560, 16'haa00, 15'h5555);
      send_pair(16'd0, 16'd0, 15'd0, 16'd1, 16'd1, 15'd1);
      send_pair(16'd10, 16'd20, 15'd30, 16'd13, 16'd24, 15'd0);
      send_pair(CMIN, CMAX, RMAX, CMAX, CMIN, 15'd0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 150) idle_off = 1'b1;
         send_random_pair();
      end
      req_valid <= 1'b0;
      while (pending_count != 0 || u_checker.placement_queue.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("[circle_collision_resolve_top] OK");
      end else begin
         $display("[circle_collision_resolve_top] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/ccr_pkg.sv
hdl/ccr_sqrt.sv
hdl/ccr_div.sv
hdl/circle_collision_resolve_top.sv
dv/ccr_checker.sv
dv/tb_top.sv
